[hdl/rrqd_pkg.sv]
// ----------------------------------------------------------------------------
// rrqd_pkg
// Types, constants and codes shared by the round-robin quantum dispatcher.
// ----------------------------------------------------------------------------
package rrqd_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W          = 8;
	localparam int BURST_W       = 16;
	localparam int REC_W         = ID_W + BURST_W;
	localparam int QCOUNT_W      = 5;
	localparam int STATUS_W      = 2;
	localparam logic [BURST_W-1:0] RESET_QUANTUM = 16'd20;

	typedef enum logic [0:0] {
		CMD_ENQUEUE  = 1'b0,
		CMD_DISPATCH = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DONE
	} state_t;

	// outcome of one dispatch against the quantum
	typedef struct packed {
		logic [BURST_W-1:0] length;
		logic               finished;
		logic [BURST_W-1:0] remain;
	} slice_t;

	typedef struct packed {
		status_t            status;
		logic [ID_W-1:0]    owner;
		logic [BURST_W-1:0] length;
		logic               finished;
		logic [CNT_W-1:0]   count;
	} result_t;

endpackage

[hdl/round_robin_quantum_dispatcher.sv]
// ----------------------------------------------------------------------------
// round_robin_quantum_dispatcher
// Round-robin ready queue with a time quantum, one result item per command.
// ----------------------------------------------------------------------------
// The ready queue is a 16-entry FIFO of {id, burst} records in a RAM with a
// registered read. Commands are taken one at a time, each only after the
// last is handed to the output register. An enqueue, or a dispatch on an
// empty queue, goes straight to hand-off; a popping dispatch steps through
// head read, compare/subtract and write-back, then hand-off. A finished
// result waits in the output register while the next command is accepted.
// The quantum register may be written at any cycle and resets to 20; it
// needs no clearing pass, since RAM entries are only read after being written.
// ----------------------------------------------------------------------------
module round_robin_quantum_dispatcher (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rrqd_pkg::BURST_W-1:0]  cfg_data,
	// commands
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [rrqd_pkg::ID_W-1:0]     process_id,
	input  logic [rrqd_pkg::BURST_W-1:0]  burst_time,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rrqd_pkg::STATUS_W-1:0] status,
	output logic [rrqd_pkg::ID_W-1:0]     slice_owner,
	output logic [rrqd_pkg::BURST_W-1:0]  slice_length,
	output logic                          process_finished,
	output logic [rrqd_pkg::QCOUNT_W-1:0] queue_count
);
	import rrqd_pkg::*;

	state_t             state_q, state_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [PTR_W-1:0]   tail_q, tail_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [BURST_W-1:0] quantum_q;
	result_t            res_q, res_d;
	result_t            out_q;
	logic               out_valid_q;
	logic               out_load;

	logic               mem_we;
	logic [REC_W-1:0]   mem_wdata;
	logic [REC_W-1:0]   mem_rdata;
	slice_t             slice;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	// head is always presented; data is used only in the cycle after a pop
	rrqd_ram #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(REC_W),
		.AW   (PTR_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(tail_q),
		.wdata(mem_wdata),
		.raddr(head_q),
		.rdata(mem_rdata)
	);

	rrqd_slicer u_slicer (
		.burst  (mem_rdata[BURST_W-1:0]),
		.quantum(quantum_q),
		.slice  (slice)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= RESET_QUANTUM;
		end else if (cfg_valid) begin
			quantum_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_wdata = {process_id, burst_time};
		out_load  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_d = '{status: STAT_OK, owner: '0, length: '0,
						finished: 1'b0, count: count_q};
					state_d = ST_DONE;
					if (cmd_t'(command) == CMD_ENQUEUE) begin
						if (count_q == CNT_W'(QUEUE_DEPTH)) begin
							res_d.status = STAT_FULL;
						end else begin
							mem_we      = 1'b1;
							tail_d      = next_slot(tail_q);
							count_d     = CNT_W'(count_q + 1'b1);
							res_d.count = count_d;
						end
					end else if (count_q == '0) begin
						res_d.status = STAT_EMPTY;
					end else begin
						// pop: RAM latches the head record at this edge
						head_d  = next_slot(head_q);
						count_d = CNT_W'(count_q - 1'b1);
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				res_d = '{status: STAT_OK, owner: mem_rdata[REC_W-1:BURST_W],
					length: slice.length, finished: slice.finished,
					count: count_q};
				if (!slice.finished) begin
					// a slot was just freed, so the re-append always fits
					mem_we      = 1'b1;
					mem_wdata   = {mem_rdata[REC_W-1:BURST_W], slice.remain};
					tail_d      = next_slot(tail_q);
					count_d     = CNT_W'(count_q + 1'b1);
					res_d.count = count_d;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign slice_owner      = out_q.owner;
	assign slice_length     = out_q.length;
	assign process_finished = out_q.finished;
	assign queue_count      = QCOUNT_W'(out_q.count);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty queue with head and tail apart");

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_DONE))
		else $error("head read did not complete in one cycle");

	a_finished_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && process_finished) |-> (status == STAT_OK))
		else $error("finished slice with non-ok status");

endmodule

[hdl/rrqd_ram.sv]
// ----------------------------------------------------------------------------
// rrqd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rrqd_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 24,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/rrqd_slicer.sv]
// ----------------------------------------------------------------------------
// rrqd_slicer
// Compares a record's remaining burst to the quantum and splits off a slice.
// ----------------------------------------------------------------------------
module rrqd_slicer (
	input  logic [rrqd_pkg::BURST_W-1:0] burst,
	input  logic [rrqd_pkg::BURST_W-1:0] quantum,
	output rrqd_pkg::slice_t             slice
);
	import rrqd_pkg::*;

	logic fits;

	assign fits           = (burst <= quantum);
	assign slice.finished = fits;
	assign slice.length   = fits ? burst : quantum;
	assign slice.remain   = burst - quantum;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin quantum dispatcher.
// ----------------------------------------------------------------------------
// Commands go in through a valid/ready channel. Each accepted command is run
// through a software copy of the ready queue, which records the slice that
// the block should grant. Every result item is checked against the oldest
// recorded slice. The quantum is rewritten between phases while the block is
// idle. Both channels idle at random, and once the result side is held off
// long enough that the command side backs up.
// ----------------------------------------------------------------------------
module tb;

	localparam int HOLD_OFF_CYCLES = 300;

	class ready_queue_tracker;
		typedef struct {
			logic [rrqd_pkg::STATUS_W-1:0] status;
			logic [rrqd_pkg::ID_W-1:0]     owner;
			logic [rrqd_pkg::BURST_W-1:0]  length;
			logic                          finished;
			logic [rrqd_pkg::QCOUNT_W-1:0] count;
		} grant_t;

		logic [rrqd_pkg::REC_W-1:0]   ready_recs[$];
		grant_t                       grants_due[$];
		logic [rrqd_pkg::BURST_W-1:0] quantum;
		int                           fail_count;

		function new();
			quantum    = rrqd_pkg::RESET_QUANTUM;
			fail_count = 0;
		endfunction

		function void set_quantum(logic [rrqd_pkg::BURST_W-1:0] q);
			quantum = q;
		endfunction

		function int waiting();
			return ready_recs.size();
		endfunction

		function int outstanding();
			return grants_due.size();
		endfunction

		function void apply_command(rrqd_pkg::cmd_t cmd, logic [rrqd_pkg::ID_W-1:0] id,
				logic [rrqd_pkg::BURST_W-1:0] burst);
			grant_t                       g;
			logic [rrqd_pkg::REC_W-1:0]   rec;
			logic [rrqd_pkg::BURST_W-1:0] left;
			g.status   = rrqd_pkg::STAT_OK;
			g.owner    = '0;
			g.length   = '0;
			g.finished = 1'b0;
			if (cmd == rrqd_pkg::CMD_ENQUEUE) begin
				if (ready_recs.size() >= rrqd_pkg::QUEUE_DEPTH)
					g.status = rrqd_pkg::STAT_FULL;
				else
					ready_recs.push_back({id, burst});
			end else if (ready_recs.size() == 0) begin
				g.status = rrqd_pkg::STAT_EMPTY;
			end else begin
				rec     = ready_recs.pop_front();
				g.owner = rec[rrqd_pkg::REC_W-1:rrqd_pkg::BURST_W];
				left    = rec[rrqd_pkg::BURST_W-1:0];
				if (left <= quantum) begin
					g.length   = left;
					g.finished = 1'b1;
				end else begin
					// unfinished process goes back to the tail with what is left
					g.length = quantum;
					ready_recs.push_back({g.owner, left - quantum});
				end
			end
			g.count = 5'(ready_recs.size());
			grants_due.push_back(g);
		endfunction

		function void compare_slice(logic [rrqd_pkg::STATUS_W-1:0] st,
				logic [rrqd_pkg::ID_W-1:0] owner, logic [rrqd_pkg::BURST_W-1:0] length,
				logic finished, logic [rrqd_pkg::QCOUNT_W-1:0] count);
			grant_t g;
			if (grants_due.size() == 0) begin
				$error("result item with nothing outstanding (status %0d owner %0d)",
					st, owner);
				fail_count++;
				return;
			end
			g = grants_due.pop_front();
			if (st !== g.status) begin
				$error("status: expected %0d, got %0d", g.status, st);
				fail_count++;
			end
			if (owner !== g.owner) begin
				$error("slice_owner: expected %0d, got %0d", g.owner, owner);
				fail_count++;
			end
			if (length !== g.length) begin
				$error("slice_length: expected %0d, got %0d", g.length, length);
				fail_count++;
			end
			if (finished !== g.finished) begin
				$error("process_finished: expected %0d, got %0d", g.finished, finished);
				fail_count++;
			end
			if (count !== g.count) begin
				$error("queue_count: expected %0d, got %0d", g.count, count);
				fail_count++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [rrqd_pkg::BURST_W-1:0]  cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          command = 1'b0;
	logic [rrqd_pkg::ID_W-1:0]     process_id = '0;
	logic [rrqd_pkg::BURST_W-1:0]  burst_time = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [rrqd_pkg::STATUS_W-1:0] status;
	logic [rrqd_pkg::ID_W-1:0]     slice_owner;
	logic [rrqd_pkg::BURST_W-1:0]  slice_length;
	logic                          process_finished;
	logic [rrqd_pkg::QCOUNT_W-1:0] queue_count;

	ready_queue_tracker tracker = new();
	int                 in_streak = 0;
	int                 out_streak = 0;
	bit                 hold_request = 1'b0;

	round_robin_quantum_dispatcher dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.process_id       (process_id),
		.burst_time       (burst_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.slice_owner      (slice_owner),
		.slice_length     (slice_length),
		.process_finished (process_finished),
		.queue_count      (queue_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_command(rrqd_pkg::cmd_t cmd, logic [rrqd_pkg::ID_W-1:0] id,
			logic [rrqd_pkg::BURST_W-1:0] burst);
		int gap;
		if (in_streak > 0) begin
			gap = 0;
			in_streak--;
		end else begin
			gap = $urandom_range(0, 15);
			if ($urandom_range(0, 9) == 0)
				in_streak = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		process_id <= id;
		burst_time <= burst;
		do @(posedge clk); while (!in_ready);
		tracker.apply_command(cmd, id, burst);
	endtask

	task automatic write_quantum(logic [rrqd_pkg::BURST_W-1:0] q);
		while (tracker.outstanding() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= q;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_quantum(q);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [rrqd_pkg::BURST_W-1:0] pick_burst();
		int lim;
		lim = tracker.quantum * 3;
		if (lim > 65535)
			lim = 65535;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'($urandom);
			2: return '1;
			default: return 16'($urandom_range(1, lim));
		endcase
	endfunction

	task automatic run_random(int n);
		rrqd_pkg::cmd_t cmd;
		int             depth;
		repeat (n) begin
			depth = tracker.waiting();
			if (depth == 0)
				cmd = ($urandom_range(0, 99) < 85) ? rrqd_pkg::CMD_ENQUEUE
					: rrqd_pkg::CMD_DISPATCH;
			else if (depth >= rrqd_pkg::QUEUE_DEPTH)
				cmd = ($urandom_range(0, 99) < 75) ? rrqd_pkg::CMD_DISPATCH
					: rrqd_pkg::CMD_ENQUEUE;
			else
				cmd = $urandom_range(0, 1) ? rrqd_pkg::CMD_DISPATCH : rrqd_pkg::CMD_ENQUEUE;
			send_command(cmd, 8'($urandom_range(0, 255)), pick_burst());
		end
		in_valid <= 1'b0;
	endtask

	// result side
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				gap          = HOLD_OFF_CYCLES;
				hold_request = 1'b0;
			end else if (out_streak > 0) begin
				gap = 0;
				out_streak--;
			end else begin
				gap = $urandom_range(0, 15);
				if ($urandom_range(0, 9) == 0)
					out_streak = $urandom_range(10, 40);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			tracker.compare_slice(status, slice_owner, slice_length, process_finished,
				queue_count);
		end
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dispatch, zero and full-scale records, fill, overflow,
		// then pops that finish, slice and re-append at the reset quantum
		send_command(rrqd_pkg::CMD_DISPATCH, 8'hFF, 16'hFFFF);
		send_command(rrqd_pkg::CMD_ENQUEUE, 8'h00, 16'h0000);
		send_command(rrqd_pkg::CMD_ENQUEUE, 8'hFF, 16'hFFFF);
		send_command(rrqd_pkg::CMD_ENQUEUE, 8'h01, 16'd20);
		send_command(rrqd_pkg::CMD_ENQUEUE, 8'h02, 16'd21);
		for (int i = 3; i < rrqd_pkg::QUEUE_DEPTH; i++)
			send_command(rrqd_pkg::CMD_ENQUEUE, 8'(i), 16'($urandom_range(1, 60)));
		send_command(rrqd_pkg::CMD_ENQUEUE, 8'hAA, 16'h5555);
		repeat (5) send_command(rrqd_pkg::CMD_DISPATCH, 8'($urandom), 16'($urandom));
		in_valid <= 1'b0;

		write_quantum(16'd1);
		run_random(80);
		write_quantum(16'hFFFF);
		hold_request = 1'b1;
		run_random(80);
		write_quantum(16'($urandom_range(2, 100)));
		run_random(80);
		write_quantum(16'($urandom_range(1, 65535)));
		run_random(80);
		write_quantum(16'd5);
		run_random(80);

		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[round_robin_quantum_dispatcher.f]
hdl/rrqd_pkg.sv
hdl/rrqd_ram.sv
hdl/rrqd_slicer.sv
hdl/round_robin_quantum_dispatcher.sv
verif/tb.sv
